/* src/dbes_pkg.sv */
`default_nettype none

package dbes_pkg;

    localparam int DELAY_BITS   = 16;
    localparam int TIMEOUT_BITS = 24;
    localparam int BCNT_W       = DELAY_BITS + 1;
    localparam int TCNT_W       = TIMEOUT_BITS + 1;
    localparam int CFG_DATA_W   = (DELAY_BITS > TIMEOUT_BITS) ? DELAY_BITS : TIMEOUT_BITS;
    localparam int CFG_IDX_W    = 3;
    localparam int ALARM_N      = 3;

    typedef logic [DELAY_BITS-1:0]   t_delay;
    typedef logic [TIMEOUT_BITS-1:0] t_timeout;
    typedef logic [BCNT_W-1:0]       t_bcnt;
    typedef logic [TCNT_W-1:0]       t_tcnt;
    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]   t_cfg_data;

    // register indexes on the config port
    localparam t_cfg_idx REG_BRAKE_ENABLE         = 3'd0;
    localparam t_cfg_idx REG_BRAKE_OPEN_DELAY     = 3'd1;
    localparam t_cfg_idx REG_BRAKE_CLOSE_AHEAD    = 3'd2;
    localparam t_cfg_idx REG_ENABLE_TIMEOUT       = 3'd3;
    localparam t_cfg_idx REG_REDUCE_TORQUE_ENABLE = 3'd4;
    localparam t_cfg_idx REG_ALARM_MASK           = 3'd5;
    localparam t_cfg_idx REG_RESET_DEFINED        = 3'd6;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_ALARM0      = 3'd1;
    localparam logic [2:0] ERR_ALARM1      = 3'd2;
    localparam logic [2:0] ERR_ALARM2      = 3'd3;
    localparam logic [2:0] ERR_INTERLOCKED = 3'd4;
    localparam logic [2:0] ERR_TIMEOUT     = 3'd5;

    typedef enum logic [1:0] {
        PH_CLOSED  = 2'd0,
        PH_OPENING = 2'd1,
        PH_OPEN    = 2'd2,
        PH_CLOSING = 2'd3
    } t_phase;

    typedef struct packed {
        logic     brake_enable;
        t_delay   brake_open_delay;
        t_delay   brake_close_ahead;
        t_timeout enable_timeout;
        logic     reduce_torque_enable;
        logic [2:0] alarm_mask;
        logic     reset_defined;
    } t_cfg;

    typedef struct packed {
        t_phase     phase;
        t_bcnt      brake_ticks;
        t_tcnt      timeout_ticks;
        logic       prev_enable;
        logic       prev_feedback;
        logic       brake_out;
        logic [2:0] err;
        logic       reset_pending;
    } t_state;

    typedef struct packed {
        logic       enable_cmd;
        logic       drive_enabled;
        logic       interlock;
        logic       at_target;
        logic [2:0] alarm_bits;
        logic       error_reset;
    } t_in_item;

    typedef struct packed {
        logic       amp_enable;
        logic       brake_release;
        logic       reduce_torque;
        logic       hw_reset;
        logic       enabled_status;
        logic       effective_enable;
        logic [2:0] error_code;
        logic       enabled_lost;
        logic [1:0] brake_phase;
    } t_out_item;

endpackage

`default_nettype wire

/* src/dbes_in_if.sv */
`default_nettype none

interface dbes_in_if;
    logic               valid;
    logic               ready;
    dbes_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/dbes_out_if.sv */
`default_nettype none

interface dbes_out_if;
    logic                valid;
    logic                ready;
    dbes_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/dbes_step.sv */
`default_nettype none

// One tick of the enable / brake update, purely combinational.
module dbes_step (
    input  wire dbes_pkg::t_cfg      i_cfg,
    input  wire dbes_pkg::t_state    i_state,
    input  wire dbes_pkg::t_in_item  i_item,
    output dbes_pkg::t_state         o_state,
    output dbes_pkg::t_out_item      o_res
);

    always_comb begin
        logic               en;
        logic               fb;
        logic               amp;
        logic               status;
        logic               lost;
        logic               hwr;
        logic [2:0]         hit;
        logic [2:0]         err;
        logic               pend;
        dbes_pkg::t_phase   ph;
        dbes_pkg::t_bcnt    bt;
        dbes_pkg::t_tcnt    tt;
        logic               bo;

        fb     = i_item.drive_enabled;
        en     = i_item.enable_cmd;
        err    = i_state.err;
        pend   = i_state.reset_pending;
        ph     = i_state.phase;
        bt     = i_state.brake_ticks;
        tt     = i_state.timeout_ticks;
        bo     = i_state.brake_out;
        lost   = 1'b0;
        hwr    = 1'b0;

        if (i_item.error_reset) begin
            err = dbes_pkg::ERR_NONE;
            if (i_cfg.reset_defined) begin
                pend = 1'b1;
            end
        end

        // connected alarms; highest numbered alarm wins the code
        hit = i_cfg.alarm_mask & i_item.alarm_bits;
        if (hit != 3'b000) begin
            en = 1'b0;
        end
        if (hit[2]) begin
            err = dbes_pkg::ERR_ALARM2;
        end else if (hit[1]) begin
            err = dbes_pkg::ERR_ALARM1;
        end else if (hit[0]) begin
            err = dbes_pkg::ERR_ALARM0;
        end

        if (i_item.interlock && en) begin
            en  = 1'b0;
            err = dbes_pkg::ERR_INTERLOCKED;
        end

        if (i_cfg.brake_enable) begin
            status = fb && i_state.brake_out;
            if (en && !i_state.prev_enable) begin
                ph = dbes_pkg::PH_OPENING;
                bt = '0;
            end
            if (!en && i_state.prev_enable) begin
                ph = dbes_pkg::PH_CLOSING;
                bt = '0;
            end
            amp = 1'b0;
            unique case (ph)
                dbes_pkg::PH_OPENING: begin
                    amp = 1'b1;
                    if (bt > {1'b0, i_cfg.brake_open_delay}) begin
                        if (!fb) begin
                            en  = 1'b0;
                            bo  = 1'b0;
                            bt  = '0;
                            amp = 1'b0;
                            ph  = dbes_pkg::PH_CLOSED;
                        end else begin
                            ph = dbes_pkg::PH_OPEN;
                            bo = 1'b1;
                        end
                    end
                    if (i_state.prev_feedback && !fb) begin
                        ph  = dbes_pkg::PH_CLOSED;
                        amp = 1'b0;
                        bo  = 1'b0;
                    end
                    if (fb) begin
                        bt = bt + dbes_pkg::t_bcnt'(1);
                    end
                end
                dbes_pkg::PH_OPEN: begin
                    bt = '0;
                    if (!fb && en) begin
                        bo  = 1'b0;
                        amp = 1'b0;
                        ph  = dbes_pkg::PH_CLOSED;
                    end else begin
                        bo  = 1'b1;
                        amp = 1'b1;
                    end
                end
                dbes_pkg::PH_CLOSING: begin
                    bo  = 1'b0;
                    amp = 1'b1;
                    if (bt > {1'b0, i_cfg.brake_close_ahead} || !fb) begin
                        ph  = dbes_pkg::PH_CLOSED;
                        amp = 1'b0;
                    end
                    bt = bt + dbes_pkg::t_bcnt'(1);
                end
                default: begin
                    bo  = 1'b0;
                    bt  = '0;
                    amp = 1'b0;
                end
            endcase
        end else begin
            status = fb;
            amp    = en;
        end

        if (i_cfg.reset_defined) begin
            hwr  = pend;
            pend = 1'b0;
        end

        if (!fb && en) begin
            tt = tt + dbes_pkg::t_tcnt'(1);
            if (tt > {1'b0, i_cfg.enable_timeout}) begin
                tt  = '0;
                en  = 1'b0;
                err = dbes_pkg::ERR_TIMEOUT;
            end
        end else begin
            tt = '0;
        end

        if (!fb && i_state.prev_feedback && en) begin
            en   = 1'b0;
            lost = 1'b1;
        end

        o_state.phase         = ph;
        o_state.brake_ticks   = bt;
        o_state.timeout_ticks = tt;
        o_state.prev_enable   = en;
        o_state.prev_feedback = fb;
        o_state.brake_out     = bo;
        o_state.err           = err;
        o_state.reset_pending = pend;

        o_res.amp_enable       = amp;
        o_res.brake_release    = i_cfg.brake_enable && bo;
        o_res.reduce_torque    = i_cfg.reduce_torque_enable && i_item.at_target;
        o_res.hw_reset         = hwr;
        o_res.enabled_status   = status;
        o_res.effective_enable = en;
        o_res.error_code       = err;
        o_res.enabled_lost     = lost;
        o_res.brake_phase      = ph;
    end

endmodule

`default_nettype wire

/* src/drive_brake_enable_sequencer_core.sv */
`default_nettype none

// Drive enable and brake sequencer. Each request on i_in is one control tick:
// the axis enable command, drive feedback, interlock, at-target, three alarm
// inputs and an error reset. Every request yields exactly one result on o_out
// carrying amplifier enable, brake release, reduce-torque, a one-tick hardware
// reset pulse, status, the effective enable, a sticky last-wins error code,
// the enabled-lost flag and the brake phase. One request per clock is taken:
// the whole tick update is a single combinational pass from the accepted
// request and the state registers into the state and the result register,
// and i_in.ready stays high unless the result register is full and o_out is
// stalled. Registers are written through the plain write port (i_cfg_we /
// i_cfg_idx / i_cfg_data); the user must do so only while the block is idle,
// the block does not enforce it. Writes to unused indexes are dropped.
module drive_brake_enable_sequencer_core (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire dbes_pkg::t_cfg_idx    i_cfg_idx,
    input  wire dbes_pkg::t_cfg_data   i_cfg_data,
    dbes_in_if.sink                    i_in,
    dbes_out_if.source                 o_out
);

    dbes_pkg::t_cfg      r_cfg;
    dbes_pkg::t_state    r_state;
    dbes_pkg::t_state    n_state;
    dbes_pkg::t_out_item n_res;
    dbes_pkg::t_out_item r_res;
    logic                r_res_valid;
    logic                in_fire;

    // result register frees up in the same cycle it is taken
    assign i_in.ready = !r_res_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    assign o_out.valid = r_res_valid;
    assign o_out.data  = r_res;

    // config registers, masked to their widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dbes_pkg::REG_BRAKE_ENABLE: begin
                    r_cfg.brake_enable <= i_cfg_data[0];
                end
                dbes_pkg::REG_BRAKE_OPEN_DELAY: begin
                    r_cfg.brake_open_delay <= i_cfg_data[dbes_pkg::DELAY_BITS-1:0];
                end
                dbes_pkg::REG_BRAKE_CLOSE_AHEAD: begin
                    r_cfg.brake_close_ahead <= i_cfg_data[dbes_pkg::DELAY_BITS-1:0];
                end
                dbes_pkg::REG_ENABLE_TIMEOUT: begin
                    r_cfg.enable_timeout <= i_cfg_data[dbes_pkg::TIMEOUT_BITS-1:0];
                end
                dbes_pkg::REG_REDUCE_TORQUE_ENABLE: begin
                    r_cfg.reduce_torque_enable <= i_cfg_data[0];
                end
                dbes_pkg::REG_ALARM_MASK: begin
                    r_cfg.alarm_mask <= i_cfg_data[2:0];
                end
                dbes_pkg::REG_RESET_DEFINED: begin
                    r_cfg.reset_defined <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // tick update: phase/brake sequencer, timeout, error code, reset pulse
    dbes_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_item  (i_in.data),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // state advances only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= dbes_pkg::PH_CLOSED;
            r_state.brake_ticks   <= '0;
            r_state.timeout_ticks <= '0;
            r_state.prev_enable   <= 1'b0;
            r_state.prev_feedback <= 1'b0;
            r_state.brake_out     <= 1'b0;
            r_state.err           <= dbes_pkg::ERR_NONE;
            r_state.reset_pending <= 1'b0;
            r_res_valid           <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state     <= n_state;
                r_res_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

// Checks the drive enable / brake sequencer one control tick at a time.
// Every accepted request is run through a local copy of the sequencer state
// and the expected outputs are queued; the result monitor pops them in order
// and compares field by field. Registers are only changed once the block has
// drained. Both handshakes get random idle bursts, one long output hold
// forces the block to stall its input, and the last part runs with no gaps.
module testbench;
    import dbes_pkg::*;

    localparam int DRAIN_CYCLES = 4;   // result reg plus a little margin

    logic      i_clk;
    logic      i_rst_n;
    logic      cfg_we;
    t_cfg_idx  cfg_idx;
    t_cfg_data cfg_data;

    dbes_in_if  tick_in ();
    dbes_out_if tick_out ();

    drive_brake_enable_sequencer_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (tick_in),
        .o_out      (tick_out)
    );

    // Local copy of the register file and the sequencer state
    t_cfg       regs;
    t_phase     seq_phase;
    t_bcnt      brake_ticks;
    t_tcnt      timeout_ticks;
    logic       last_enable;
    logic       last_feedback;
    logic       brake_open;
    logic [2:0] sticky_err;
    logic       hw_reset_armed;

    t_out_item pending_outputs[$];
    int        fault_count = 0;

    // Idle control shared by the request driver and the result sink
    bit gaps_on     = 1'b1;
    int hold_cycles = 0;

    // Random request shaping: enable level and lagging drive feedback
    logic gen_cmd = 1'b0;
    logic gen_fb  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("drive_brake_enable_sequencer_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: one control tick of the sequencer
    // ------------------------------------------------------------------
    function automatic t_out_item sequencer_step(input t_in_item it);
        logic      en;
        logic      fb;
        logic      amp;
        logic      status;
        logic      lost;
        logic      hwr;
        t_out_item r;

        en   = it.enable_cmd;
        fb   = it.drive_enabled;
        lost = 1'b0;
        hwr  = 1'b0;

        // error reset goes first, then alarms 0..2 (last one wins the code)
        if (it.error_reset) begin
            sticky_err = ERR_NONE;
            if (regs.reset_defined)
                hw_reset_armed = 1'b1;
        end
        for (int i = 0; i < ALARM_N; i++) begin
            if (regs.alarm_mask[i] && it.alarm_bits[i]) begin
                en         = 1'b0;
                sticky_err = ERR_ALARM0 + 3'(i);
            end
        end
        if (it.interlock && en) begin
            en         = 1'b0;
            sticky_err = ERR_INTERLOCKED;
        end

        if (regs.brake_enable) begin
            status = fb && brake_open;
            // enable edges restart the sequencer
            if (en && !last_enable) begin
                seq_phase   = PH_OPENING;
                brake_ticks = '0;
            end
            if (!en && last_enable) begin
                seq_phase   = PH_CLOSING;
                brake_ticks = '0;
            end
            amp = 1'b0;
            case (seq_phase)
                PH_OPENING: begin
                    amp = 1'b1;
                    if (brake_ticks > {1'b0, regs.brake_open_delay}) begin
                        if (!fb) begin
                            // brake open failed: no feedback at delay expiry
                            en          = 1'b0;
                            brake_open  = 1'b0;
                            brake_ticks = '0;
                            amp         = 1'b0;
                            seq_phase   = PH_CLOSED;
                        end else begin
                            seq_phase  = PH_OPEN;
                            brake_open = 1'b1;
                        end
                    end
                    if (last_feedback && !fb) begin
                        seq_phase  = PH_CLOSED;
                        amp        = 1'b0;
                        brake_open = 1'b0;
                    end
                    if (fb)
                        brake_ticks = brake_ticks + t_bcnt'(1);
                end
                PH_OPEN: begin
                    brake_ticks = '0;
                    if (!fb && en) begin
                        brake_open = 1'b0;
                        amp        = 1'b0;
                        seq_phase  = PH_CLOSED;
                    end else begin
                        brake_open = 1'b1;
                        amp        = 1'b1;
                    end
                end
                PH_CLOSING: begin
                    // brake already applied, amp held for close-ahead ticks
                    brake_open = 1'b0;
                    amp        = 1'b1;
                    if (brake_ticks > {1'b0, regs.brake_close_ahead} || !fb) begin
                        seq_phase = PH_CLOSED;
                        amp       = 1'b0;
                    end
                    brake_ticks = brake_ticks + t_bcnt'(1);
                end
                default: begin
                    brake_open  = 1'b0;
                    brake_ticks = '0;
                    amp         = 1'b0;
                end
            endcase
        end else begin
            status = fb;
            amp    = en;
        end

        // an armed reset is pulsed out in the same tick
        if (regs.reset_defined) begin
            hwr            = hw_reset_armed;
            hw_reset_armed = 1'b0;
        end

        if (!fb && en) begin
            timeout_ticks = timeout_ticks + t_tcnt'(1);
            if (timeout_ticks > {1'b0, regs.enable_timeout}) begin
                timeout_ticks = '0;
                en            = 1'b0;
                sticky_err    = ERR_TIMEOUT;
            end
        end else begin
            timeout_ticks = '0;
        end

        if (!fb && last_feedback && en) begin
            en   = 1'b0;
            lost = 1'b1;
        end

        last_feedback = fb;
        last_enable   = en;

        r.amp_enable       = amp;
        r.brake_release    = regs.brake_enable && brake_open;
        r.reduce_torque    = regs.reduce_torque_enable && it.at_target;
        r.hw_reset         = hwr;
        r.enabled_status   = status;
        r.effective_enable = en;
        r.error_code       = sticky_err;
        r.enabled_lost     = lost;
        r.brake_phase      = seq_phase;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fault_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        t_out_item a;
        if (i_rst_n && tick_out.valid && tick_out.ready) begin
            a = tick_out.data;
            if (pending_outputs.size() == 0) begin
                $error("result with no request outstanding");
                fault_count++;
            end else begin
                e = pending_outputs.pop_front();
                check_field("amp_enable", e.amp_enable, a.amp_enable);
                check_field("brake_release", e.brake_release, a.brake_release);
                check_field("reduce_torque", e.reduce_torque, a.reduce_torque);
                check_field("hw_reset", e.hw_reset, a.hw_reset);
                check_field("enabled_status", e.enabled_status, a.enabled_status);
                check_field("effective_enable", e.effective_enable, a.effective_enable);
                check_field("error_code", e.error_code, a.error_code);
                check_field("enabled_lost", e.enabled_lost, a.enabled_lost);
                check_field("brake_phase", e.brake_phase, a.brake_phase);
            end
        end
    end

    // Result sink: random stall bursts, plus one long hold on request
    initial begin
        tick_out.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                tick_out.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                tick_out.ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                tick_out.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                tick_out.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver and register access
    // ------------------------------------------------------------------

    // valid is left high after an accept so back-to-back requests never
    // lower and raise it in the same step
    task automatic send_tick(input t_in_item it);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            tick_in.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        tick_in.valid <= 1'b1;
        tick_in.data  <= it;
        @(posedge i_clk);
        while (!tick_in.ready) @(posedge i_clk);
        pending_outputs.push_back(sequencer_step(it));
    endtask

    // stop requesting and wait for every outstanding result
    task automatic drain_results();
        tick_in.valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_BRAKE_ENABLE:         regs.brake_enable         = val[0];
            REG_BRAKE_OPEN_DELAY:     regs.brake_open_delay     = val[DELAY_BITS-1:0];
            REG_BRAKE_CLOSE_AHEAD:    regs.brake_close_ahead    = val[DELAY_BITS-1:0];
            REG_ENABLE_TIMEOUT:       regs.enable_timeout       = val[TIMEOUT_BITS-1:0];
            REG_REDUCE_TORQUE_ENABLE: regs.reduce_torque_enable = val[0];
            REG_ALARM_MASK:           regs.alarm_mask           = val[2:0];
            REG_RESET_DEFINED:        regs.reset_defined        = val[0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic be, input t_delay open_d, input t_delay close_a,
                                input t_timeout tmo, input logic rte, input logic [2:0] mask,
                                input logic rd);
        write_reg(REG_BRAKE_ENABLE, t_cfg_data'(be));
        write_reg(REG_BRAKE_OPEN_DELAY, t_cfg_data'(open_d));
        write_reg(REG_BRAKE_CLOSE_AHEAD, t_cfg_data'(close_a));
        write_reg(REG_ENABLE_TIMEOUT, t_cfg_data'(tmo));
        write_reg(REG_REDUCE_TORQUE_ENABLE, t_cfg_data'(rte));
        write_reg(REG_ALARM_MASK, t_cfg_data'(mask));
        write_reg(REG_RESET_DEFINED, t_cfg_data'(rd));
    endtask

    function automatic t_in_item tick_of(input logic en, input logic fb, input logic ilk,
                                         input logic at, input logic [2:0] alarms,
                                         input logic er);
        t_in_item it;
        it.enable_cmd    = en;
        it.drive_enabled = fb;
        it.interlock     = ilk;
        it.at_target     = at;
        it.alarm_bits    = alarms;
        it.error_reset   = er;
        return it;
    endfunction

    // Mostly plausible tick streams: the enable toggles now and then, the
    // drive feedback follows with some lag and drops out rarely; alarms,
    // interlocks and error resets are sparse. One tick in ten is pure noise.
    function automatic t_in_item next_random_tick();
        logic [$bits(t_in_item)-1:0] raw;
        t_in_item it;
        raw = $bits(t_in_item)'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            it = raw;
            return it;
        end
        if ($urandom_range(0, 11) == 0)
            gen_cmd = !gen_cmd;
        if (gen_fb != gen_cmd && $urandom_range(0, 1) == 1)
            gen_fb = gen_cmd;
        if ($urandom_range(0, 39) == 0)
            gen_fb = 1'b0;
        it = tick_of(gen_cmd, gen_fb, $urandom_range(0, 29) == 0, raw[0],
                     ($urandom_range(0, 24) == 0) ? 3'($urandom_range(1, 7)) : 3'b000,
                     $urandom_range(0, 14) == 0);
        return it;
    endfunction

    task automatic apply_random_config();
        t_delay   open_d;
        t_delay   close_a;
        t_timeout tmo;
        // small delays keep the sequencer cycling; now and then a big one
        open_d  = ($urandom_range(0, 7) == 0) ? t_delay'($urandom) : t_delay'($urandom_range(0, 6));
        close_a = ($urandom_range(0, 7) == 0) ? t_delay'($urandom) : t_delay'($urandom_range(0, 6));
        tmo     = ($urandom_range(0, 5) == 0) ? t_timeout'($urandom)
                                              : t_timeout'($urandom_range(0, 12));
        apply_config($urandom_range(0, 3) != 0, open_d, close_a, tmo, 1'($urandom_range(0, 1)),
                     3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_random_ticks(input int n);
        repeat (n) send_tick(next_random_tick());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain pass-through: field extremes, each alarm, interlock, error reset
    // with a reset output, enable timeout and feedback lost while enabled.
    task automatic test_direct_enable_path();
        apply_config(1'b0, '0, '0, 24'd2, 1'b1, 3'b111, 1'b1);
        send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b0, 3'b000, 1'b0));
        send_tick(tick_of(1'b1, 1'b1, 1'b1, 1'b1, 3'b111, 1'b1));
        send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b1, 3'b001, 1'b0));
        send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b0, 3'b010, 1'b0));
        send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b1, 3'b100, 1'b0));
        send_tick(tick_of(1'b1, 1'b1, 1'b1, 1'b0, 3'b000, 1'b0));
        send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b0, 3'b000, 1'b1));
        send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b0, 3'b000, 1'b0));
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 3'b000, 1'b0));     // feedback lost
        repeat (3) send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b1, 3'b000, 1'b0));  // runs into timeout
        drain_results();
    endtask

    // Brake sequencing: open after the delay, close ahead, an error reset
    // while no reset output exists (nothing arms), and a brake open that fails.
    task automatic test_brake_sequence();
        apply_config(1'b1, 16'd2, 16'd1, 24'd20, 1'b0, 3'b000, 1'b0);
        repeat (5) send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b1, 3'b000, 1'b0));
        repeat (3) send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b0, 3'b000, 1'b0));
        send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b0, 3'b000, 1'b1));      // clears the error, arms nothing
        drain_results();
        write_reg(REG_RESET_DEFINED, t_cfg_data'(1'b1));
        send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b0, 3'b000, 1'b0));      // no pending pulse to show
        drain_results();
        write_reg(REG_BRAKE_OPEN_DELAY, '0);
        send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b0, 3'b000, 1'b0));
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 3'b000, 1'b0));      // no feedback at expiry
        send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b0, 3'b000, 1'b0));
        drain_results();
    endtask

    // Several register settings, the extremes among them; one phase has no
    // idling at all so back-to-back traffic is covered mid-run too.
    task automatic test_random_settings();
        apply_config(1'b0, '0, '0, '0, 1'b0, 3'b000, 1'b0);
        send_random_ticks(100);
        drain_results();
        apply_config(1'b1, '1, '1, '1, 1'b1, 3'b111, 1'b1);
        send_random_ticks(100);
        drain_results();
        apply_config(1'b1, '0, '0, '0, 1'b1, 3'b111, 1'b1);
        send_random_ticks(100);
        drain_results();
        for (int p = 0; p < 4; p++) begin
            gaps_on = (p != 2);
            apply_random_config();
            send_random_ticks(80);
            drain_results();
        end
        gaps_on = 1'b1;
    endtask

    // Long output hold while requests keep coming: the result register
    // fills and the block must stall its input without losing a tick.
    task automatic test_output_stall();
        apply_config(1'b1, 16'd3, 16'd2, 24'd5, 1'b1, 3'b101, 1'b1);
        gaps_on     = 1'b0;
        hold_cycles = 60;
        send_random_ticks(40);
        drain_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        apply_random_config();
        send_random_ticks(100);
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= REG_BRAKE_ENABLE;
        cfg_data      <= '0;
        tick_in.valid <= 1'b0;
        tick_in.data  <= '0;

        regs           = '0;
        seq_phase      = PH_CLOSED;
        brake_ticks    = '0;
        timeout_ticks  = '0;
        last_enable    = 1'b0;
        last_feedback  = 1'b0;
        brake_open     = 1'b0;
        sticky_err     = ERR_NONE;
        hw_reset_armed = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_direct_enable_path();
        test_brake_sequence();
        test_random_settings();
        test_output_stall();
        test_back_to_back();

        if (fault_count == 0)
            $display("drive_brake_enable_sequencer_core: match");
        else
            $display("drive_brake_enable_sequencer_core: mismatch");
        $finish;
    end

endmodule

/* drive_brake_enable_sequencer_core.f */
src/dbes_pkg.sv
src/dbes_in_if.sv
src/dbes_out_if.sv
src/dbes_step.sv
src/drive_brake_enable_sequencer_core.sv
test/testbench.sv
